### design/plate_element_pressure_load_vector_core_macros.svh
// Assertion macros shared by the checker of the plate element load core.
// No dependencies; include once per checker file.
`ifndef PLATE_ELEMENT_PRESSURE_LOAD_VECTOR_CORE_MACROS_SVH
`define PLATE_ELEMENT_PRESSURE_LOAD_VECTOR_CORE_MACROS_SVH

// Concurrent check, masked while reset is held
`define PELV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check that also runs through reset
`define PELV_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/pelv_pkg.sv
// Package of the plate element pressure load core: types, constants and
// quadrature tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pelv_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int ACCUM_WIDTH_DEF = 48;
    localparam int GQ              = 30;
    localparam int COORD_W         = 32;
    localparam int PRES_W          = 32;
    localparam int ORDER_W         = 3;
    localparam int LOAD_W          = 48;
    localparam int DOF_W           = 6;
    localparam int OP_W            = 64;
    localparam int VW              = 40;

    localparam logic CFG_ORDER    = 1'b0;
    localparam logic CFG_PRESSURE = 1'b1;

    typedef enum logic [4:0] {
        S_LOAD, S_PT, S_T2, S_T3, S_POLY,
        S_HR, S_HS, S_JX11, S_JX12, S_JX21, S_JX22,
        S_DET1, S_DET2, S_WW, S_WT, S_WP,
        S_H, S_TERM, S_WAIT, S_LD, S_OUT
    } t_state;

    // Control of the shared multiply unit
    typedef struct packed {
        logic start;
        logic frac_sh;   // shift by FRAC_BITS, else by GQ
        logic acc_sat;   // saturate to ACCUM_WIDTH, else to 64 bits
    } t_mul_ctl;

    // Gauss points, Q30
    function automatic logic signed [31:0] gauss_pt(input logic [1:0] nm1,
                                                    input logic [1:0] i);
        logic signed [31:0] v;
        case ({nm1, i})
            4'b0100: v = -32'sd619925131;
            4'b0101: v =  32'sd619925131;
            4'b1000: v = -32'sd831716840;
            4'b1010: v =  32'sd831716840;
            4'b1100: v = -32'sd924638074;
            4'b1101: v = -32'sd365051866;
            4'b1110: v =  32'sd365051866;
            4'b1111: v =  32'sd924638074;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Gauss weights, Q30
    function automatic logic signed [32:0] gauss_wt(input logic [1:0] nm1,
                                                    input logic [1:0] i);
        logic signed [32:0] v;
        case ({nm1, i})
            4'b0000: v = 33'sd2147483648;
            4'b0100: v = 33'sd1073741824;
            4'b0101: v = 33'sd1073741824;
            4'b1000: v = 33'sd596523236;
            4'b1001: v = 33'sd954437177;
            4'b1010: v = 33'sd596523236;
            4'b1100: v = 33'sd373506296;
            4'b1101: v = 33'sd700235528;
            4'b1110: v = 33'sd700235528;
            4'b1111: v = 33'sd373506296;
            default: v = '0;
        endcase
        return v;
    endfunction

    // 16 * L_i(t) = c0 t^3 + c1 t^2 + c2 t + c3
    function automatic logic signed [7:0] poly_c(input logic [1:0] i,
                                                 input logic [1:0] j);
        logic signed [7:0] v;
        case ({i, j})
            4'b0000: v = -8'sd9;
            4'b0001: v =  8'sd9;
            4'b0010: v =  8'sd1;
            4'b0011: v = -8'sd1;
            4'b0100: v =  8'sd27;
            4'b0101: v = -8'sd9;
            4'b0110: v = -8'sd27;
            4'b0111: v =  8'sd9;
            4'b1000: v = -8'sd27;
            4'b1001: v = -8'sd9;
            4'b1010: v =  8'sd27;
            4'b1011: v =  8'sd9;
            4'b1100: v =  8'sd9;
            4'b1101: v =  8'sd9;
            4'b1110: v = -8'sd1;
            default: v = -8'sd1;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/plate_element_pressure_load_vector_core.sv
// Top level of the plate element pressure load core: node stores, load
// accumulator memory and quadrature sequencer. Depends on pelv_pkg, pelv_mul.
//
// Usage:
//   Input channel (i_valid / o_stall): one node (x, y) per transfer; the
//   transfer with i_node_last closes the element. Nodes past the sixteenth
//   are dropped. o_stall is high from the last node until the final result
//   of the element has been transferred.
//   Output channel (o_valid / i_stall): 48 results, dof_index 0..47, with
//   result_last on the 48th; a non-positive Jacobian determinant gives one
//   result with status 1 instead.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; index 0 is
//   the integration order, index 1 the pressure.
// Sequencing: all products go through one shared multiply unit, one product
//   at a time; the quadrature runs over n*n points (n points per direction),
//   then the results are sent, subject to receiver stalls.
// Reset: empties the node count, sets order 4 and pressure 1.0. A stalled
//   result holds until it is transferred.
`timescale 1ns / 1ps
`default_nettype none

module plate_element_pressure_load_vector_core
    import pelv_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic signed [COORD_W-1:0] i_node_x,
    input  wire logic signed [COORD_W-1:0] i_node_y,
    input  wire logic                      i_node_last,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [DOF_W-1:0]               o_dof_index,
    output logic signed [LOAD_W-1:0]       o_load_value,
    output logic                           o_status,
    output logic                           o_result_last,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [PRES_W-1:0]         i_cfg_data
);

    localparam logic signed [47:0] ONE_Q  = 48'sd1 <<< GQ;
    localparam logic signed [64:0] AMAX   = (65'sd1 <<< (ACCUM_WIDTH - 1)) - 65'sd1;
    localparam logic signed [64:0] AMIN   = -AMAX - 65'sd1;
    localparam logic signed [63:0] LMAX   = 64'sd140737488355327;
    localparam logic signed [63:0] LMIN   = -64'sd140737488355328;

    // Memories
    logic [COORD_W-1:0]     x_mem [16];
    logic [COORD_W-1:0]     y_mem [16];
    logic [ACCUM_WIDTH-1:0] acc_mem [16];

    // Control registers
    t_state           r_state, n_state;
    logic [4:0]       r_count;
    logic [ORDER_W-1:0] r_order;
    logic signed [PRES_W-1:0] r_pressure;
    logic [1:0]       r_nm1;
    logic             r_mbusy;
    logic [3:0]       r_k;
    logic [1:0]       r_pi;
    logic             r_dim;
    logic [1:0]       r_ix;
    logic [1:0]       r_iy;
    logic [1:0]       r_j;
    logic [DOF_W-1:0] r_dof;
    logic             r_first;
    logic             r_err;
    logic             r_o_valid;

    // Datapath registers
    logic signed [COORD_W-1:0] r_xrd;
    logic signed [COORD_W-1:0] r_yrd;
    logic [ACCUM_WIDTH-1:0]    r_accrd;
    logic signed [31:0]   r_t;
    logic signed [VW-1:0] r_t2;
    logic signed [VW-1:0] r_t3;
    logic signed [VW-1:0] r_val [2][4];
    logic signed [VW-1:0] r_der [2][4];
    logic signed [63:0]   r_hr, r_hs, r_h;
    logic signed [63:0]   r_j11, r_j12, r_j21, r_j22;
    logic signed [63:0]   r_p1, r_det, r_ww, r_wt, r_wp;
    logic [DOF_W-1:0]     r_o_dof;
    logic signed [LOAD_W-1:0] r_o_val;
    logic                 r_o_status;
    logic                 r_o_last;

    // Combinational signals
    logic             w_in_xfer;
    logic             w_out_xfer;
    logic [1:0]       w_nm1;
    t_mul_ctl         w_mctl;
    logic signed [63:0] w_a, w_b;
    logic             w_done;
    logic signed [63:0] w_res;
    logic signed [63:0] w_det;
    logic             w_bad;
    logic             w_lastpt;
    logic signed [47:0] w_v, w_d;
    logic signed [VW-1:0] w_pv, w_pd;
    logic signed [64:0] w_sum;
    logic [ACCUM_WIDTH-1:0] w_newacc;
    logic signed [63:0] w_acce;
    logic signed [LOAD_W-1:0] w_load;

    // Round a 1D polynomial by 1/16, ties away from zero
    function automatic logic signed [VW-1:0] rnd4(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [47:0] m;
        mag = v[47] ? (48'd0 - 48'(v)) : 48'(v);
        m   = (mag + 48'd8) >> 4;
        return VW'(v[47] ? signed'(48'd0 - m) : signed'(m));
    endfunction

    pelv_mul #(
        .FRAC_BITS   (FRAC_BITS),
        .ACCUM_WIDTH (ACCUM_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_xfer = r_o_valid && !i_stall;
    assign w_lastpt   = (r_ix == r_nm1) && (r_iy == r_nm1);
    assign w_det      = r_p1 - w_res;
    assign w_bad      = w_det[63] || (w_det == 64'sd0);

    // Clamp the integration order to 1..4
    always_comb begin
        if (r_order == 3'd0) begin
            w_nm1 = 2'd0;
        end else if (r_order > 3'd4) begin
            w_nm1 = 2'd3;
        end else begin
            w_nm1 = 2'(r_order - 3'd1);
        end
    end

    // 1D polynomial value and derivative for index r_pi
    always_comb begin
        w_v = 48'(poly_c(r_pi, 2'd0)) * 48'(r_t3) + 48'(poly_c(r_pi, 2'd1)) * 48'(r_t2)
            + 48'(poly_c(r_pi, 2'd2)) * 48'(r_t) + 48'(poly_c(r_pi, 2'd3)) * ONE_Q;
        w_d = 48'sd3 * 48'(poly_c(r_pi, 2'd0)) * 48'(r_t2)
            + 48'sd2 * 48'(poly_c(r_pi, 2'd1)) * 48'(r_t)
            + 48'(poly_c(r_pi, 2'd2)) * ONE_Q;
        w_pv = rnd4(w_v);
        w_pd = rnd4(w_d);
    end

    // Saturating accumulate and output clip
    always_comb begin
        w_sum = 65'(signed'(r_accrd)) + 65'(w_res);
        if (r_first) begin
            w_newacc = w_res[ACCUM_WIDTH-1:0];
        end else if (w_sum > AMAX) begin
            w_newacc = AMAX[ACCUM_WIDTH-1:0];
        end else if (w_sum < AMIN) begin
            w_newacc = AMIN[ACCUM_WIDTH-1:0];
        end else begin
            w_newacc = w_sum[ACCUM_WIDTH-1:0];
        end
        w_acce = 64'(signed'(r_accrd));
        if (w_acce > LMAX) begin
            w_load = LMAX[LOAD_W-1:0];
        end else if (w_acce < LMIN) begin
            w_load = LMIN[LOAD_W-1:0];
        end else begin
            w_load = w_acce[LOAD_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (w_in_xfer && i_node_last) n_state = S_PT;
            S_PT:   n_state = S_T2;
            S_T2:   if (w_done) n_state = S_T3;
            S_T3:   if (w_done) n_state = S_POLY;
            S_POLY: if (r_pi == 2'd3) n_state = r_dim ? S_HR : S_PT;
            S_HR:   if (w_done) n_state = S_HS;
            S_HS:   if (w_done) n_state = S_JX11;
            S_JX11: if (w_done) n_state = S_JX12;
            S_JX12: if (w_done) n_state = S_JX21;
            S_JX21: if (w_done) n_state = S_JX22;
            S_JX22: if (w_done) n_state = (r_k == 4'd15) ? S_DET1 : S_HR;
            S_DET1: if (w_done) n_state = S_DET2;
            S_DET2: if (w_done) n_state = w_bad ? S_OUT : S_WW;
            S_WW:   if (w_done) n_state = S_WT;
            S_WT:   if (w_done) n_state = S_WP;
            S_WP:   if (w_done) n_state = S_H;
            S_H:    if (w_done) n_state = S_TERM;
            S_TERM: begin
                if (w_done) begin
                    if (r_k != 4'd15) n_state = S_H;
                    else n_state = w_lastpt ? S_WAIT : S_PT;
                end
            end
            S_WAIT: n_state = S_LD;
            S_LD:   n_state = S_OUT;
            S_OUT: begin
                if (w_out_xfer) begin
                    if (r_err || r_o_last) n_state = S_LOAD;
                    else if (r_j == 2'd2) n_state = S_WAIT;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Multiply unit operands and start
    always_comb begin
        w_mctl.start   = 1'b0;
        w_mctl.frac_sh = 1'b0;
        w_mctl.acc_sat = 1'b0;
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            S_T2:   begin w_a = 64'(r_t);  w_b = 64'(r_t); end
            S_T3:   begin w_a = 64'(r_t2); w_b = 64'(r_t); end
            S_HR:   begin w_a = 64'(r_der[0][r_k[3:2]]); w_b = 64'(r_val[1][r_k[1:0]]); end
            S_HS:   begin w_a = 64'(r_val[0][r_k[3:2]]); w_b = 64'(r_der[1][r_k[1:0]]); end
            S_JX11: begin w_a = r_hr; w_b = 64'(r_xrd); end
            S_JX12: begin w_a = r_hr; w_b = 64'(r_yrd); end
            S_JX21: begin w_a = r_hs; w_b = 64'(r_xrd); end
            S_JX22: begin w_a = r_hs; w_b = 64'(r_yrd); end
            S_DET1: begin w_a = r_j11; w_b = r_j22; w_mctl.frac_sh = 1'b1; end
            S_DET2: begin w_a = r_j21; w_b = r_j12; w_mctl.frac_sh = 1'b1; end
            S_WW:   begin w_a = 64'(gauss_wt(r_nm1, r_ix)); w_b = 64'(gauss_wt(r_nm1, r_iy)); end
            S_WT:   begin w_a = r_ww; w_b = r_det; end
            S_WP:   begin w_a = r_wt; w_b = 64'(r_pressure); w_mctl.frac_sh = 1'b1; end
            S_H:    begin w_a = 64'(r_val[0][r_k[3:2]]); w_b = 64'(r_val[1][r_k[1:0]]); end
            S_TERM: begin w_a = r_h; w_b = r_wp; w_mctl.acc_sat = 1'b1; end
            default: ;
        endcase
        case (r_state)
            S_T2, S_T3, S_HR, S_HS, S_JX11, S_JX12, S_JX21, S_JX22,
            S_DET1, S_DET2, S_WW, S_WT, S_WP, S_H, S_TERM:
                w_mctl.start = !r_mbusy;
            default: w_mctl.start = 1'b0;
        endcase
    end

    // Control registers: state, counters, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_order    <= 3'd4;
            r_pressure <= 32'sd65536;
            r_nm1      <= '0;
            r_mbusy    <= 1'b0;
            r_k        <= '0;
            r_pi       <= '0;
            r_dim      <= 1'b0;
            r_ix       <= '0;
            r_iy       <= '0;
            r_j        <= '0;
            r_dof      <= '0;
            r_first    <= 1'b0;
            r_err      <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // take configuration transfers
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ORDER) r_order <= i_cfg_data[ORDER_W-1:0];
                else r_pressure <= signed'(i_cfg_data);
            end
            if (w_mctl.start) r_mbusy <= 1'b1;
            else if (w_done) r_mbusy <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (w_in_xfer) begin
                        if (i_node_last) begin
                            r_count <= '0;
                            r_nm1   <= w_nm1;
                            r_ix    <= '0;
                            r_iy    <= '0;
                            r_dim   <= 1'b0;
                            r_pi    <= '0;
                            r_k     <= '0;
                            r_first <= 1'b1;
                            r_err   <= 1'b0;
                        end else if (r_count < 5'd16) begin
                            r_count <= r_count + 5'd1;
                        end
                    end
                end
                S_POLY: begin
                    r_pi <= r_pi + 2'd1;
                    if (r_pi == 2'd3) r_dim <= ~r_dim;
                end
                S_JX22: if (w_done) r_k <= r_k + 4'd1;
                S_DET2: begin
                    if (w_done && w_bad) begin
                        r_err     <= 1'b1;
                        r_o_valid <= 1'b1;
                    end
                end
                S_TERM: begin
                    if (w_done) begin
                        r_k <= r_k + 4'd1;
                        if (r_k == 4'd15) begin
                            r_first <= 1'b0;
                            r_dof   <= '0;
                            r_j     <= '0;
                            if (r_iy == r_nm1) begin
                                r_iy <= '0;
                                r_ix <= r_ix + 2'd1;
                            end else begin
                                r_iy <= r_iy + 2'd1;
                            end
                        end
                    end
                end
                S_LD: r_o_valid <= 1'b1;
                S_OUT: begin
                    if (w_out_xfer) begin
                        if (r_err || r_o_last) begin
                            r_o_valid <= 1'b0;
                        end else if (r_j == 2'd2) begin
                            r_o_valid <= 1'b0;
                            r_j       <= '0;
                            r_k       <= r_k + 4'd1;
                            r_dof     <= r_dof + 6'd1;
                        end else begin
                            r_j   <= r_j + 2'd1;
                            r_dof <= r_dof + 6'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Node stores: write on transfer, read at the current node
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && (r_count < 5'd16)) begin
            x_mem[r_count[3:0]] <= i_node_x;
            y_mem[r_count[3:0]] <= i_node_y;
        end
        r_xrd <= signed'(x_mem[r_k]);
        r_yrd <= signed'(y_mem[r_k]);
    end

    // Load accumulator: read at the current node, write back the new sum
    always_ff @(posedge i_clk) begin
        if ((r_state == S_TERM) && w_done) begin
            acc_mem[r_k] <= w_newacc;
        end
        r_accrd <= acc_mem[r_k];
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_PT:   r_t <= gauss_pt(r_nm1, r_dim ? r_iy : r_ix);
            S_T2:   if (w_done) r_t2 <= w_res[VW-1:0];
            S_T3:   if (w_done) r_t3 <= w_res[VW-1:0];
            S_POLY: begin
                r_val[r_dim][r_pi] <= w_pv;
                r_der[r_dim][r_pi] <= w_pd;
                if ((r_pi == 2'd3) && r_dim) begin
                    r_j11 <= '0;
                    r_j12 <= '0;
                    r_j21 <= '0;
                    r_j22 <= '0;
                end
            end
            S_HR:   if (w_done) r_hr <= w_res;
            S_HS:   if (w_done) r_hs <= w_res;
            S_JX11: if (w_done) r_j11 <= r_j11 + w_res;
            S_JX12: if (w_done) r_j12 <= r_j12 + w_res;
            S_JX21: if (w_done) r_j21 <= r_j21 + w_res;
            S_JX22: if (w_done) r_j22 <= r_j22 + w_res;
            S_DET1: if (w_done) r_p1 <= w_res;
            S_DET2: begin
                if (w_done) begin
                    r_det <= w_det;
                    if (w_bad) begin
                        r_o_dof    <= '0;
                        r_o_val    <= '0;
                        r_o_status <= 1'b1;
                        r_o_last   <= 1'b1;
                    end
                end
            end
            S_WW:   if (w_done) r_ww <= w_res;
            S_WT:   if (w_done) r_wt <= w_res;
            S_WP:   if (w_done) r_wp <= w_res;
            S_H:    if (w_done) r_h <= w_res;
            S_LD: begin
                r_o_dof    <= r_dof;
                r_o_val    <= w_load;
                r_o_status <= 1'b0;
                r_o_last   <= 1'b0;
            end
            S_OUT: begin
                if (w_out_xfer && !r_err && !r_o_last && (r_j != 2'd2)) begin
                    r_o_dof  <= r_dof + 6'd1;
                    r_o_val  <= '0;
                    r_o_last <= (r_k == 4'd15) && (r_j == 2'd1);
                end
            end
            default: ;
        endcase
    end

    assign o_stall       = (r_state != S_LOAD);
    assign o_valid       = r_o_valid;
    assign o_dof_index   = r_o_dof;
    assign o_load_value  = r_o_val;
    assign o_status      = r_o_status;
    assign o_result_last = r_o_last;
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

### design/pelv_mul.sv
// Shared multiply unit: 64x64 signed product from four 32x32 partial
// products, rounded shift and saturation. Depends on pelv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pelv_mul
    import pelv_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_mul_ctl               i_ctl,
    input  wire logic signed [OP_W-1:0] i_a,
    input  wire logic signed [OP_W-1:0] i_b,
    output logic                        o_done,
    output logic signed [OP_W-1:0]      o_res
);

    localparam logic [127:0] HALF_GQ   = 128'd1 << (GQ - 1);
    localparam logic [127:0] HALF_FR   = 128'd1 << (FRAC_BITS - 1);
    localparam logic [127:0] LIMP_64   = (128'd1 << 63) - 128'd1;
    localparam logic [127:0] LIMN_64   = 128'd1 << 63;
    localparam logic [127:0] LIMP_ACC  = (128'd1 << (ACCUM_WIDTH - 1)) - 128'd1;
    localparam logic [127:0] LIMN_ACC  = 128'd1 << (ACCUM_WIDTH - 1);

    logic             r_run;
    logic [2:0]       r_ph;
    logic [63:0]      r_ua;
    logic [63:0]      r_ub;
    logic             r_neg;
    logic             r_frac;
    logic             r_acc;
    logic [127:0]     r_prod;
    logic [127:0]     r_q;
    logic             r_done;
    logic signed [63:0] r_res;

    logic [63:0]      w_pp;
    logic [127:0]     w_ppx;
    logic [127:0]     w_lim;
    logic [63:0]      w_mag;

    // Pick the partial product of this phase
    always_comb begin
        case (r_ph[1:0])
            2'd0:    w_pp = r_ua[31:0]  * r_ub[31:0];
            2'd1:    w_pp = r_ua[31:0]  * r_ub[63:32];
            2'd2:    w_pp = r_ua[63:32] * r_ub[31:0];
            default: w_pp = r_ua[63:32] * r_ub[63:32];
        endcase
        case (r_ph[1:0])
            2'd0:    w_ppx = {64'd0, w_pp};
            2'd3:    w_ppx = {w_pp, 64'd0};
            default: w_ppx = {32'd0, w_pp, 32'd0};
        endcase
    end

    // Saturation limit and clipped magnitude
    always_comb begin
        if (r_acc) begin
            w_lim = r_neg ? LIMN_ACC : LIMP_ACC;
        end else begin
            w_lim = r_neg ? LIMN_64 : LIMP_64;
        end
        w_mag = (r_q > w_lim) ? w_lim[63:0] : r_q[63:0];
    end

    // Control: phase counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_ph   <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_run  <= 1'b1;
                r_ph   <= '0;
                r_done <= 1'b0;
            end else if (r_run) begin
                r_ph   <= r_ph + 3'd1;
                r_done <= (r_ph == 3'd5);
                if (r_ph == 3'd5) begin
                    r_run <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // Datapath: magnitudes, accumulate, round, saturate
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_ua   <= i_a[63] ? (64'd0 - 64'(i_a)) : 64'(i_a);
            r_ub   <= i_b[63] ? (64'd0 - 64'(i_b)) : 64'(i_b);
            r_neg  <= i_a[63] ^ i_b[63];
            r_frac <= i_ctl.frac_sh;
            r_acc  <= i_ctl.acc_sat;
            r_prod <= '0;
        end else if (r_run) begin
            if (r_ph <= 3'd3) begin
                r_prod <= r_prod + w_ppx;
            end else if (r_ph == 3'd4) begin
                if (r_frac) begin
                    r_q <= (r_prod + HALF_FR) >> FRAC_BITS;
                end else begin
                    r_q <= (r_prod + HALF_GQ) >> GQ;
                end
            end else begin
                r_res <= r_neg ? signed'(64'd0 - w_mag) : signed'(w_mag);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

### design/pelv_chk.sv
// Port checker of the plate element pressure load core and its bind.
// Depends on the core's macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "plate_element_pressure_load_vector_core_macros.svh"

module pelv_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [5:0]  o_dof_index,
    input wire logic [47:0] o_load_value,
    input wire logic        o_status,
    input wire logic        o_result_last
);

    // Hold a stalled result
    `PELV_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid, "result dropped while stalled")

    // Keep a stalled result unchanged
    `PELV_ASSERT(a_out_stable, o_valid && i_stall |=> $stable({o_dof_index, o_load_value,
                 o_status, o_result_last}), "stalled result changed")

    // Drop result valid under reset
    `PELV_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_valid, "result valid after reset")

    // Refuse nodes while a result is pending
    `PELV_ASSERT(a_busy_in, o_valid |-> o_stall, "node taken while result pending")

    // Error result is the last and carries zero
    `PELV_ASSERT(a_err_form, o_valid && o_status |-> o_result_last && (o_load_value == 48'd0),
                 "malformed error result")

endmodule

bind plate_element_pressure_load_vector_core pelv_chk u_pelv_chk (.*);

`default_nettype wire

### tb/sv/plate_element_pressure_load_vector_core_test.sv
// Self-checking bench for the plate element pressure load core: predicts the
// 48-entry load vector of each element and compares every result transfer.
// Depends on pelv_pkg and plate_element_pressure_load_vector_core.
`timescale 1ns / 1ps

// Expected result of one output transfer
typedef struct {
    bit [5:0]  dof;
    bit [47:0] load;
    bit        status;
    bit        last;
} t_load_entry;

class load_vector_board;
    bit [31:0]   x_nodes[16];
    bit [31:0]   y_nodes[16];
    int unsigned node_cnt;
    bit [2:0]    order;
    longint      pres;
    t_load_entry expected_q[$];
    int unsigned mismatches;

    function new();
        node_cnt   = 0;
        order      = 3'd4;
        pres       = 65536;
        mismatches = 0;
    endfunction

    // Round to nearest (ties away from zero), shift, saturate to width bits
    function longint mul_round(longint a, longint b, int sh, int width);
        bit        neg;
        bit [63:0] ua, ub;
        bit [127:0] p, lim;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        p = {64'd0, ua} * {64'd0, ub};
        if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
        if (neg) begin
            lim = 128'd1 << (width - 1);
            if (p > lim) p = lim;
            return -longint'(p[63:0]);
        end
        lim = (128'd1 << (width - 1)) - 1;
        if (p > lim) p = lim;
        return longint'(p[63:0]);
    endfunction

    function longint clamp48(longint v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    function longint pt_q30(int n, int i);
        longint tbl[4][4] = '{'{0, 0, 0, 0},
                              '{-619925131, 619925131, 0, 0},
                              '{-831716840, 0, 831716840, 0},
                              '{-924638074, -365051866, 365051866, 924638074}};
        return tbl[n-1][i];
    endfunction

    function longint wt_q30(int n, int i);
        longint tbl[4][4] = '{'{64'sd2147483648, 0, 0, 0},
                              '{1073741824, 1073741824, 0, 0},
                              '{596523236, 954437177, 596523236, 0},
                              '{373506296, 700235528, 700235528, 373506296}};
        return tbl[n-1][i];
    endfunction

    // Cubic Lagrange values and slopes at t, Q30
    function void lagrange(longint t, output longint v[4], output longint d[4]);
        longint c[4][4] = '{'{-9, 9, 1, -1}, '{27, -9, -27, 9},
                            '{-27, -9, 27, 9}, '{9, 9, -1, -1}};
        longint one, t2, t3, pv, pd;
        one = 64'sd1 << 30;
        t2 = mul_round(t, t, 30, 64);
        t3 = mul_round(t2, t, 30, 64);
        for (int i = 0; i < 4; i++) begin
            pv = c[i][0] * t3 + c[i][1] * t2 + c[i][2] * t + c[i][3] * one;
            pd = 3 * c[i][0] * t2 + 2 * c[i][1] * t + c[i][2] * one;
            v[i] = mul_round(pv, 1, 4, 64);
            d[i] = mul_round(pd, 1, 4, 64);
        end
    endfunction

    function void write_reg(bit idx, bit [31:0] data);
        if (idx == pelv_pkg::CFG_ORDER) order = data[2:0];
        else pres = longint'($signed(data));
    endfunction

    // Quadrature over the stored nodes; queue the load vector or the abort
    function void integrate();
        int          n;
        longint      acc[16];
        longint      lr[4], dr[4], ls[4], ds[4];
        longint      j11, j12, j21, j22, hr, hs, xv, yv, det, ww, wt, wp, h, term;
        t_load_entry e;
        n = (order < 1) ? 1 : ((order > 4) ? 4 : order);
        foreach (acc[k]) acc[k] = 0;
        for (int ix = 0; ix < n; ix++) begin
            lagrange(pt_q30(n, ix), lr, dr);
            for (int iy = 0; iy < n; iy++) begin
                lagrange(pt_q30(n, iy), ls, ds);
                j11 = 0; j12 = 0; j21 = 0; j22 = 0;
                for (int k = 0; k < 16; k++) begin
                    hr = mul_round(dr[k/4], ls[k%4], 30, 64);
                    hs = mul_round(lr[k/4], ds[k%4], 30, 64);
                    xv = longint'($signed(x_nodes[k]));
                    yv = longint'($signed(y_nodes[k]));
                    j11 += mul_round(hr, xv, 30, 64);
                    j12 += mul_round(hr, yv, 30, 64);
                    j21 += mul_round(hs, xv, 30, 64);
                    j22 += mul_round(hs, yv, 30, 64);
                end
                det = mul_round(j11, j22, 16, 64) - mul_round(j21, j12, 16, 64);
                if (det <= 0) begin
                    e = '{dof: 6'd0, load: 48'd0, status: 1'b1, last: 1'b1};
                    expected_q.push_back(e);
                    return;
                end
                ww = mul_round(wt_q30(n, ix), wt_q30(n, iy), 30, 64);
                wt = mul_round(ww, det, 30, 64);
                wp = mul_round(wt, pres, 16, 64);
                for (int k = 0; k < 16; k++) begin
                    h = mul_round(lr[k/4], ls[k%4], 30, 64);
                    term = mul_round(h, wp, 30, 48);
                    acc[k] = clamp48(acc[k] + term);
                end
            end
        end
        for (int k = 0; k < 48; k++) begin
            e.dof    = 6'(k);
            e.load   = (k % 3 == 0) ? acc[k/3][47:0] : 48'd0;
            e.status = 1'b0;
            e.last   = (k == 47);
            expected_q.push_back(e);
        end
    endfunction

    function void note_node(bit [31:0] x, bit [31:0] y, bit last);
        if (node_cnt < 16) begin
            x_nodes[node_cnt] = x;
            y_nodes[node_cnt] = y;
            node_cnt++;
        end
        if (last) begin
            node_cnt = 0;
            integrate();
        end
    endfunction

    function void check_result(bit [5:0] dof, bit [47:0] load, bit status, bit last);
        t_load_entry e;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: dof %0d load %h status %b last %b",
                         dof, load, status, last);
            return;
        end
        e = expected_q.pop_front();
        if (e.dof != dof || e.load != load || e.status != status || e.last != last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp dof %0d load %h st %b last %b, got %0d %h %b %b",
                         e.dof, e.load, e.status, e.last, dof, load, status, last);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module plate_element_pressure_load_vector_core_test;
    import pelv_pkg::*;

    localparam int IDLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 25000;

    localparam int EL_GRID   = 0;
    localparam int EL_OVER   = 1;
    localparam int EL_EARLY  = 2;
    localparam int EL_RANDOM = 3;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_node_x;
    logic signed [COORD_W-1:0] i_node_y;
    logic                      i_node_last;
    logic                      o_valid;
    logic                      i_stall;
    logic [DOF_W-1:0]          o_dof_index;
    logic signed [LOAD_W-1:0]  o_load_value;
    logic                      o_status;
    logic                      o_result_last;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic                      i_cfg_index;
    logic [PRES_W-1:0]         i_cfg_data;

    load_vector_board board;
    bit               calm;
    bit               hold_req;
    int               idle_cycles;

    plate_element_pressure_load_vector_core uut (.*);

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Receiver side: random stall bursts, one long hold on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 63) == 0) begin
                i_stall <= 1'b0;
                repeat (60) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_dof_index, o_load_value, o_status, o_result_last);
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one node; return at the edge where it is transferred
    task automatic send_node(bit [31:0] x, bit [31:0] y, bit last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_node_x    <= x;
        i_node_y    <= y;
        i_node_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_node(x, y, last);
    endtask

    task automatic write_cfg(bit idx, bit [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Pause the sender until every expected result is in, then let it settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Nodes on an affine grid with positive orientation plus small jitter, then any extra nodes at random
    task automatic send_grid(int cx, int cy, int dx, int dy, int jit, int extra);
        bit [31:0] x, y;
        for (int k = 0; k < 16 + extra; k++) begin
            if (k < 16) begin
                x = cx + (k / 4) * dx + $urandom_range(0, 2 * jit) - jit;
                y = cy + (k % 4) * dy + $urandom_range(0, 2 * jit) - jit;
            end else begin
                x = $urandom;
                y = $urandom;
            end
            send_node(x, y, k == 15 + extra);
        end
    endtask

    task automatic send_element(int kind);
        int dx, dy, m;
        dx = $urandom_range(1 << 12, 1 << 20);
        dy = $urandom_range(1 << 12, 1 << 20);
        case (kind)
            EL_GRID: send_grid($signed($urandom) >>> 8, $signed($urandom) >>> 8,
                               dx, dy, 64, 0);
            // late last node after the sixteenth is ignored
            EL_OVER: send_grid($signed($urandom) >>> 8, $signed($urandom) >>> 8,
                               dx, dy, 64, $urandom_range(1, 3));
            // early close reuses the older slots
            EL_EARLY: begin
                m = $urandom_range(1, 15);
                for (int k = 0; k < m; k++)
                    send_node(board.x_nodes[k] + $urandom_range(0, 31),
                              board.y_nodes[k] + $urandom_range(0, 31), k == m - 1);
            end
            default: for (int k = 0; k < 16; k++) send_node($urandom, $urandom, k == 15);
        endcase
    endtask

    function automatic int pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return EL_GRID;
        if (r < 15) return EL_OVER;
        if (r < 18) return EL_EARLY;
        return EL_RANDOM;
    endfunction

    initial begin
        bit [2:0]  orders[6]    = '{3'd1, 3'd0, 3'd2, 3'd5, 3'd3, 3'd7};
        bit [31:0] pressures[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
                                    32'h0, 32'hFFFF_0000};
        board       = new();
        calm        = 1'b0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_node_x    <= '0;
        i_node_y    <= '0;
        i_node_last <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ORDER;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reference square at reset settings, then extreme corners closed early
        send_grid(-65536, -65536, 43690, 43690, 0, 0);
        send_node(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_node(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_node(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_node(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        drain();

        // Random phases, an order and a pressure setting and one element each
        for (int p = 0; p < 6; p++) begin
            write_cfg(CFG_ORDER, {29'd0, orders[p]});
            write_cfg(CFG_PRESSURE, (p == 3 || p == 4) ? $urandom : pressures[p]);
            i_cfg_valid <= 1'b0;
            calm = (p == 5);
            if (p == 2) hold_req = 1'b1;
            send_element((p == 0) ? EL_GRID : pick_kind());
            drain();
        end

        if (board.mismatches == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### sim.f
+incdir+design
design/pelv_pkg.sv
design/pelv_mul.sv
design/plate_element_pressure_load_vector_core.sv
design/pelv_chk.sv
tb/sv/plate_element_pressure_load_vector_core_test.sv
